### design/sqrs_pkg.sv
// shared types, constants and tables for the sprite quad setup block
`timescale 1ns / 1ps
`default_nettype none
package sqrs_pkg;

    localparam int POS_W      = 16;
    localparam int SRC_W      = 13;
    localparam int SCL_W      = 16;
    localparam int ANG_W      = 16;
    localparam int VERT_W     = 20;
    localparam int TEX_W      = 18;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int HALF_W     = SRC_W + SCL_W;
    localparam int EDGE_W     = SRC_W + 1;
    localparam int NUM_W      = EDGE_W + 17;
    localparam int PHASE_W    = 32;
    localparam int CRD_W      = 34;
    localparam int PROD_W     = 64;
    localparam int STEP_IDX_W = 5;
    localparam int CORDIC_PER_CYC = 6;
    localparam int DIV_PER_CYC    = 6;
    localparam int DIV_CYCLES     = TEX_W / DIV_PER_CYC;
    localparam int QUEUE_DEPTH    = 2;

    localparam int MAX_TEX_SIZE_DEF = 4096;
    localparam int ANGLE_BITS_DEF   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET      = 13'd4096;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    localparam logic signed [CRD_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [TEX_W-1:0]        TEX_MAX   = 18'd262143;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [HALF_W-1:0]        hw;
        logic [HALF_W-1:0]        hh;
        logic signed [PHASE_W-1:0] z0;
        logic                     flip;
        logic [3:0]               sat;
        logic [3:0][NUM_W-1:0]    num;
    } t_job;

    // arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
    function automatic logic [PHASE_W-1:0] atan_turn(input logic [STEP_IDX_W-1:0] idx);
        logic [PHASE_W-1:0] a;
        begin
            case (idx)
                5'd0:  a = 32'h20000000;
                5'd1:  a = 32'h12E4051E;
                5'd2:  a = 32'h09FB385B;
                5'd3:  a = 32'h051111D4;
                5'd4:  a = 32'h028B0D43;
                5'd5:  a = 32'h0145D7E1;
                5'd6:  a = 32'h00A2F61E;
                5'd7:  a = 32'h00517C55;
                5'd8:  a = 32'h0028BE53;
                5'd9:  a = 32'h00145F2F;
                5'd10: a = 32'h000A2F98;
                5'd11: a = 32'h000517CC;
                5'd12: a = 32'h00028BE6;
                5'd13: a = 32'h000145F3;
                5'd14: a = 32'h0000A2FA;
                5'd15: a = 32'h0000517D;
                5'd16: a = 32'h000028BE;
                5'd17: a = 32'h0000145F;
                5'd18: a = 32'h00000A30;
                5'd19: a = 32'h00000518;
                5'd20: a = 32'h0000028C;
                5'd21: a = 32'h00000146;
                5'd22: a = 32'h000000A3;
                5'd23: a = 32'h00000051;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage
`default_nettype wire

### design/sqrs_front.sv
// front end: config registers, request capture, size products, angle fold, texture numerators
`timescale 1ns / 1ps
`default_nettype none
module sqrs_front #(
    parameter int MAX_TEX_SIZE = sqrs_pkg::MAX_TEX_SIZE_DEF,
    parameter int ANGLE_BITS   = sqrs_pkg::ANGLE_BITS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_we,
    input  wire        [sqrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire        [sqrs_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire                                     start,
    input  wire                                     i_full,
    input  wire signed [sqrs_pkg::POS_W-1:0]        i_pos_x,
    input  wire signed [sqrs_pkg::POS_W-1:0]        i_pos_y,
    input  wire        [sqrs_pkg::SRC_W-1:0]        i_src_x,
    input  wire        [sqrs_pkg::SRC_W-1:0]        i_src_y,
    input  wire        [sqrs_pkg::SRC_W-1:0]        i_src_w,
    input  wire        [sqrs_pkg::SRC_W-1:0]        i_src_h,
    input  wire        [sqrs_pkg::SCL_W-1:0]        i_scale_x,
    input  wire        [sqrs_pkg::SCL_W-1:0]        i_scale_y,
    input  wire        [sqrs_pkg::ANG_W-1:0]        i_angle,
    output logic                                    o_push,
    output sqrs_pkg::t_job                          o_job,
    output logic [$clog2(MAX_TEX_SIZE+1)-1:0]       o_tex_w,
    output logic [$clog2(MAX_TEX_SIZE+1)-1:0]       o_tex_h
);
    localparam int DW = $clog2(MAX_TEX_SIZE + 1);
    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    logic [sqrs_pkg::CFG_W-1:0]   r_tex_w;
    logic [sqrs_pkg::CFG_W-1:0]   r_tex_h;
    logic [DW-1:0]                tw;
    logic [DW-1:0]                th;
    logic [sqrs_pkg::PHASE_W-1:0] phase;
    logic                         flip;
    logic [3:0][sqrs_pkg::EDGE_W-1:0] edge_v;
    logic [3:0][DW-1:0]           dsz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= sqrs_pkg::CFG_RESET;
            r_tex_h <= sqrs_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sqrs_pkg::CFG_TEX_WIDTH:  r_tex_w <= i_cfg_data;
                sqrs_pkg::CFG_TEX_HEIGHT: r_tex_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_tex_w == '0) begin
            tw = DW'(1);
        end else if (32'(r_tex_w) > 32'(MAX_TEX_SIZE)) begin
            tw = DW'(MAX_TEX_SIZE);
        end else begin
            tw = DW'(r_tex_w);
        end
        if (r_tex_h == '0) begin
            th = DW'(1);
        end else if (32'(r_tex_h) > 32'(MAX_TEX_SIZE)) begin
            th = DW'(MAX_TEX_SIZE);
        end else begin
            th = DW'(r_tex_h);
        end
    end

    assign o_tex_w = tw;
    assign o_tex_h = th;
    assign o_push  = start && !i_full;

    // second and third quadrant are folded by half a turn
    assign phase = 32'((32'(i_angle) & AMASK) << (32 - ANGLE_BITS));
    assign flip  = phase[31] ^ phase[30];

    assign edge_v[0] = sqrs_pkg::EDGE_W'(i_src_x);
    assign edge_v[1] = sqrs_pkg::EDGE_W'(i_src_x) + sqrs_pkg::EDGE_W'(i_src_w);
    assign edge_v[2] = sqrs_pkg::EDGE_W'(i_src_y);
    assign edge_v[3] = sqrs_pkg::EDGE_W'(i_src_y) + sqrs_pkg::EDGE_W'(i_src_h);
    assign dsz[0] = tw;
    assign dsz[1] = tw;
    assign dsz[2] = th;
    assign dsz[3] = th;

    always_comb begin
        o_job.pos_x = i_pos_x;
        o_job.pos_y = i_pos_y;
        o_job.hw    = sqrs_pkg::HALF_W'(i_src_w) * sqrs_pkg::HALF_W'(i_scale_x);
        o_job.hh    = sqrs_pkg::HALF_W'(i_src_h) * sqrs_pkg::HALF_W'(i_scale_y);
        o_job.flip  = flip;
        o_job.z0    = flip ? $signed({~phase[31], phase[30:0]}) : $signed(phase);
        for (int l = 0; l < 4; l++) begin
            o_job.num[l] = sqrs_pkg::NUM_W'({edge_v[l], 16'b0})
                         + sqrs_pkg::NUM_W'(dsz[l] >> 1);
            // quotient would not fit 18 bits
            o_job.sat[l] = 48'(o_job.num[l]) >= 48'({dsz[l], 18'b0});
        end
    end

endmodule
`default_nettype wire

### design/sqrs_queue.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module sqrs_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  sqrs_pkg::t_job  i_job,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_valid,
    output sqrs_pkg::t_job  o_job
);
    sqrs_pkg::t_job r_mem [sqrs_pkg::QUEUE_DEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_count == 2'(sqrs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

### design/sqrs_back.sv
// back end: iterative cordic and texture dividers, products, four-corner emission
`timescale 1ns / 1ps
`default_nettype none
module sqrs_back #(
    parameter int MAX_TEX_SIZE = sqrs_pkg::MAX_TEX_SIZE_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_q_valid,
    input  sqrs_pkg::t_job                          i_job,
    output logic                                    o_pop,
    input  wire  [$clog2(MAX_TEX_SIZE+1)-1:0]       i_tex_w,
    input  wire  [$clog2(MAX_TEX_SIZE+1)-1:0]       i_tex_h,
    output logic                                    o_strobe,
    output logic signed [sqrs_pkg::VERT_W-1:0]      o_vert_x,
    output logic signed [sqrs_pkg::VERT_W-1:0]      o_vert_y,
    output logic [sqrs_pkg::TEX_W-1:0]              o_tex_u,
    output logic [sqrs_pkg::TEX_W-1:0]              o_tex_v,
    output logic [1:0]                              o_corner,
    output logic                                    o_last
);
    localparam int DW = $clog2(MAX_TEX_SIZE + 1);
    localparam int RW = DW + 1;
    localparam int CW = sqrs_pkg::CRD_W;
    localparam int PW = sqrs_pkg::PROD_W;
    localparam int TW = sqrs_pkg::TEX_W;
    localparam logic signed [PW-1:0] RND  = 64'sd17179869184;
    localparam logic signed [PW-1:0] VMAX = 64'sd524287;
    localparam logic signed [PW-1:0] VMIN = -64'sd524288;

    // iteration stage
    logic                       r_a_busy;
    logic [1:0]                 r_a_cnt;
    logic signed [CW-1:0]       r_x, r_y, r_z;
    logic [3:0][RW-1:0]         r_rem;
    logic [3:0][TW-1:0]         r_nsh;
    logic [3:0][TW-1:0]         r_q;
    logic [sqrs_pkg::HALF_W-1:0] r_a_hw, r_a_hh;
    logic signed [sqrs_pkg::POS_W-1:0] r_a_px, r_a_py;
    logic                       r_a_flip;
    logic [3:0]                 r_a_sat;

    logic signed [CW-1:0]       n_x, n_y, n_z;
    logic [3:0][RW-1:0]         n_rem;
    logic [3:0][TW-1:0]         n_nsh;
    logic [3:0][TW-1:0]         n_q;
    logic [3:0][DW-1:0]         dsz;

    // hand-off stage
    logic                       r_b_valid;
    logic signed [CW-1:0]       r_b_c, r_b_s;
    logic [sqrs_pkg::HALF_W-1:0] r_b_hw, r_b_hh;
    logic signed [sqrs_pkg::POS_W-1:0] r_b_px, r_b_py;
    logic [3:0][TW-1:0]         r_b_tex;

    // emission stage
    logic                       r_c_busy;
    logic [1:0]                 r_c_k;
    logic signed [PW-1:0]       r_hwc, r_hws, r_hhc, r_hhs;
    logic signed [sqrs_pkg::POS_W-1:0] r_c_px, r_c_py;
    logic [3:0][TW-1:0]         r_c_tex;

    logic                       r_o_strobe;
    logic signed [sqrs_pkg::VERT_W-1:0] r_o_x, r_o_y;
    logic [TW-1:0]              r_o_u, r_o_v;
    logic [1:0]                 r_o_corner;

    logic step_en, a_fire, b_free, c_take;
    logic signed [PW-1:0] p_hwc, p_hws, p_hhc, p_hhs;
    logic signed [PW-1:0] sum_x, sum_y, sh_x, sh_y;
    logic signed [sqrs_pkg::VERT_W-1:0] vx, vy;

    assign dsz[0] = i_tex_w;
    assign dsz[1] = i_tex_w;
    assign dsz[2] = i_tex_h;
    assign dsz[3] = i_tex_h;

    assign c_take  = r_b_valid && (!r_c_busy || r_c_k == sqrs_pkg::CORNER_BR);
    assign b_free  = !r_b_valid || c_take;
    assign a_fire  = r_a_busy && (r_a_cnt == 2'd3) && b_free;
    assign step_en = r_a_busy && !((r_a_cnt == 2'd3) && !b_free);
    assign o_pop   = i_q_valid && (!r_a_busy || a_fire);

    // six cordic rotations, six quotient bits per cycle when not stalled
    always_comb begin
        logic signed [CW-1:0]       xs, ys;
        logic [sqrs_pkg::STEP_IDX_W-1:0] idx;
        logic signed [CW-1:0]       at;
        logic [RW-1:0]              rem;
        logic [TW-1:0]              nsh, q;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        for (int j = 0; j < sqrs_pkg::CORDIC_PER_CYC; j++) begin
            idx = sqrs_pkg::STEP_IDX_W'(r_a_cnt) * sqrs_pkg::STEP_IDX_W'(sqrs_pkg::CORDIC_PER_CYC)
                + sqrs_pkg::STEP_IDX_W'(j);
            xs = n_x >>> idx;
            ys = n_y >>> idx;
            at = $signed({2'b0, sqrs_pkg::atan_turn(idx)});
            if (n_z >= 0) begin
                n_x = n_x - ys;
                n_y = n_y + xs;
                n_z = n_z - at;
            end else begin
                n_x = n_x + ys;
                n_y = n_y - xs;
                n_z = n_z + at;
            end
        end
        for (int l = 0; l < 4; l++) begin
            rem = r_rem[l];
            nsh = r_nsh[l];
            q   = r_q[l];
            if (32'(r_a_cnt) < sqrs_pkg::DIV_CYCLES) begin
                for (int j = 0; j < sqrs_pkg::DIV_PER_CYC; j++) begin
                    rem = {rem[RW-2:0], nsh[TW-1]};
                    nsh = {nsh[TW-2:0], 1'b0};
                    if (rem >= RW'(dsz[l])) begin
                        rem = rem - RW'(dsz[l]);
                        q   = {q[TW-2:0], 1'b1};
                    end else begin
                        q   = {q[TW-2:0], 1'b0};
                    end
                end
            end
            n_rem[l] = rem;
            n_nsh[l] = nsh;
            n_q[l]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_busy <= 1'b0;
            r_a_cnt  <= '0;
        end else if (o_pop) begin
            r_a_busy <= 1'b1;
            r_a_cnt  <= '0;
        end else if (step_en) begin
            r_a_cnt <= r_a_cnt + 2'd1;
            if (a_fire) begin
                r_a_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x      <= sqrs_pkg::CORDIC_X0;
            r_y      <= '0;
            r_z      <= CW'(i_job.z0);
            r_a_hw   <= i_job.hw;
            r_a_hh   <= i_job.hh;
            r_a_px   <= i_job.pos_x;
            r_a_py   <= i_job.pos_y;
            r_a_flip <= i_job.flip;
            r_a_sat  <= i_job.sat;
            for (int l = 0; l < 4; l++) begin
                r_rem[l] <= RW'(i_job.num[l] >> TW);
                r_nsh[l] <= i_job.num[l][TW-1:0];
                r_q[l]   <= '0;
            end
        end else if (step_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_rem <= n_rem;
            r_nsh <= n_nsh;
            r_q   <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_fire) begin
            r_b_valid <= 1'b1;
        end else if (c_take) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_c  <= r_a_flip ? -n_x : n_x;
            r_b_s  <= r_a_flip ? -n_y : n_y;
            r_b_hw <= r_a_hw;
            r_b_hh <= r_a_hh;
            r_b_px <= r_a_px;
            r_b_py <= r_a_py;
            for (int l = 0; l < 4; l++) begin
                r_b_tex[l] <= r_a_sat[l] ? sqrs_pkg::TEX_MAX : r_q[l];
            end
        end
    end

    assign p_hwc = $signed({1'b0, r_b_hw}) * r_b_c;
    assign p_hws = $signed({1'b0, r_b_hw}) * r_b_s;
    assign p_hhc = $signed({1'b0, r_b_hh}) * r_b_c;
    assign p_hhs = $signed({1'b0, r_b_hh}) * r_b_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_busy <= 1'b0;
            r_c_k    <= '0;
        end else if (c_take) begin
            r_c_busy <= 1'b1;
            r_c_k    <= sqrs_pkg::CORNER_TL;
        end else if (r_c_busy) begin
            if (r_c_k == sqrs_pkg::CORNER_BR) begin
                r_c_busy <= 1'b0;
            end
            r_c_k <= r_c_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take) begin
            r_hwc   <= p_hwc;
            r_hws   <= p_hws;
            r_hhc   <= p_hhc;
            r_hhs   <= p_hhs;
            r_c_px  <= r_b_px;
            r_c_py  <= r_b_py;
            r_c_tex <= r_b_tex;
        end
    end

    // corner offsets are +/- half size; rotate, add centre, round to Q.4
    always_comb begin
        sum_x = (r_c_k[0] ? r_hwc : -r_hwc) + (r_c_k[1] ? -r_hhs : r_hhs)
              + (PW'(r_c_px) <<< 35) + RND;
        sum_y = (r_c_k[0] ? r_hws : -r_hws) + (r_c_k[1] ? r_hhc : -r_hhc)
              + (PW'(r_c_py) <<< 35) + RND;
        sh_x = sum_x >>> 35;
        sh_y = sum_y >>> 35;
        if (sh_x > VMAX) begin
            vx = sqrs_pkg::VERT_W'(VMAX);
        end else if (sh_x < VMIN) begin
            vx = sqrs_pkg::VERT_W'(VMIN);
        end else begin
            vx = sqrs_pkg::VERT_W'(sh_x);
        end
        if (sh_y > VMAX) begin
            vy = sqrs_pkg::VERT_W'(VMAX);
        end else if (sh_y < VMIN) begin
            vy = sqrs_pkg::VERT_W'(VMIN);
        end else begin
            vy = sqrs_pkg::VERT_W'(sh_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= r_c_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_x      <= vx;
        r_o_y      <= vy;
        r_o_u      <= r_c_k[0] ? r_c_tex[1] : r_c_tex[0];
        r_o_v      <= r_c_k[1] ? r_c_tex[3] : r_c_tex[2];
        r_o_corner <= r_c_k;
    end

    assign o_strobe = r_o_strobe;
    assign o_vert_x = r_o_x;
    assign o_vert_y = r_o_y;
    assign o_tex_u  = r_o_u;
    assign o_tex_v  = r_o_v;
    assign o_corner = r_o_corner;
    assign o_last   = (r_o_corner == sqrs_pkg::CORNER_BR);

    a_corner_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_strobe && r_o_corner != sqrs_pkg::CORNER_BR |=>
            r_o_strobe && r_o_corner == $past(r_o_corner) + 2'd1)
        else $error("corner sequence broken");

    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_fire |=> r_b_valid)
        else $error("finished job not handed off");

    a_quad_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_strobe) |-> r_o_corner == sqrs_pkg::CORNER_TL)
        else $error("quad does not start at top-left");

endmodule
`default_nettype wire

### design/sprite_quad_rotate_scale_setup.sv
// top level of the sprite quad scale / rotate / translate setup block
//
// Command channel: a draw request is taken at a clock edge where start is
// high and busy is low. busy rises only while the two-entry request queue
// is full.
// Config port: i_cfg_we writes i_cfg_data into texture width (index 0) or
// texture height (index 1) at once; other indexes are dropped. Write only
// while the block is idle.
// Result channel: each request yields four vertices (top-left, top-right,
// bottom-left, bottom-right) on consecutive cycles, each shown for one
// cycle with o_strobe high; o_last marks the fourth. The receiver cannot
// stall, so results are never held back.
// Path: queue, iteration stage, hand-off register, emission stage and
// output registers; earlier stages wait while a later one is full. Rate
// set by the cordic unit (six rotations per cycle over 24) and emission.
// Reset: synchronous active low; both texture sizes return to 4096 and all
// queued or in-flight requests are dropped.
`timescale 1ns / 1ps
`default_nettype none
module sprite_quad_rotate_scale_setup #(
    parameter int MAX_TEX_SIZE = sqrs_pkg::MAX_TEX_SIZE_DEF,
    parameter int ANGLE_BITS   = sqrs_pkg::ANGLE_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire        [sqrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire        [sqrs_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                                 start,
    output logic                                busy,
    input  wire signed [sqrs_pkg::POS_W-1:0]    i_pos_x,
    input  wire signed [sqrs_pkg::POS_W-1:0]    i_pos_y,
    input  wire        [sqrs_pkg::SRC_W-1:0]    i_src_x,
    input  wire        [sqrs_pkg::SRC_W-1:0]    i_src_y,
    input  wire        [sqrs_pkg::SRC_W-1:0]    i_src_w,
    input  wire        [sqrs_pkg::SRC_W-1:0]    i_src_h,
    input  wire        [sqrs_pkg::SCL_W-1:0]    i_scale_x,
    input  wire        [sqrs_pkg::SCL_W-1:0]    i_scale_y,
    input  wire        [sqrs_pkg::ANG_W-1:0]    i_angle,
    output logic                                o_strobe,
    output logic signed [sqrs_pkg::VERT_W-1:0]  o_vert_x,
    output logic signed [sqrs_pkg::VERT_W-1:0]  o_vert_y,
    output logic       [sqrs_pkg::TEX_W-1:0]    o_tex_u,
    output logic       [sqrs_pkg::TEX_W-1:0]    o_tex_v,
    output logic       [1:0]                    o_corner,
    output logic                                o_last
);
    localparam int DW = $clog2(MAX_TEX_SIZE + 1);

    logic           push, pop, full, q_valid;
    sqrs_pkg::t_job f_job, q_job;
    logic [DW-1:0]  tex_w, tex_h;

    assign busy = full;

    sqrs_front #(
        .MAX_TEX_SIZE (MAX_TEX_SIZE),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .i_full     (full),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_src_x    (i_src_x),
        .i_src_y    (i_src_y),
        .i_src_w    (i_src_w),
        .i_src_h    (i_src_h),
        .i_scale_x  (i_scale_x),
        .i_scale_y  (i_scale_y),
        .i_angle    (i_angle),
        .o_push     (push),
        .o_job      (f_job),
        .o_tex_w    (tex_w),
        .o_tex_h    (tex_h)
    );

    sqrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    sqrs_back #(
        .MAX_TEX_SIZE (MAX_TEX_SIZE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .i_tex_w   (tex_w),
        .i_tex_h   (tex_h),
        .o_strobe  (o_strobe),
        .o_vert_x  (o_vert_x),
        .o_vert_y  (o_vert_y),
        .o_tex_u   (o_tex_u),
        .o_tex_v   (o_tex_v),
        .o_corner  (o_corner),
        .o_last    (o_last)
    );

endmodule
`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the sprite quad scale / rotate / translate setup block
`timescale 1ns / 1ps
module testbench;

    typedef enum logic [1:0] {OP_DRAW, OP_CFG, OP_DRAIN} t_op;

    typedef struct {
        t_op                                op;
        logic signed [sqrs_pkg::POS_W-1:0]  pos_x;
        logic signed [sqrs_pkg::POS_W-1:0]  pos_y;
        logic [sqrs_pkg::SRC_W-1:0]         src_x;
        logic [sqrs_pkg::SRC_W-1:0]         src_y;
        logic [sqrs_pkg::SRC_W-1:0]         src_w;
        logic [sqrs_pkg::SRC_W-1:0]         src_h;
        logic [sqrs_pkg::SCL_W-1:0]         scale_x;
        logic [sqrs_pkg::SCL_W-1:0]         scale_y;
        logic [sqrs_pkg::ANG_W-1:0]         angle;
        logic [sqrs_pkg::CFG_IDX_W-1:0]     cfg_idx;
        logic [sqrs_pkg::CFG_W-1:0]         cfg_data;
    } t_sprite_req;

    typedef struct {
        logic signed [sqrs_pkg::VERT_W-1:0] vert_x;
        logic signed [sqrs_pkg::VERT_W-1:0] vert_y;
        logic [sqrs_pkg::TEX_W-1:0]         tex_u;
        logic [sqrs_pkg::TEX_W-1:0]         tex_v;
        logic [1:0]                         corner;
        logic                               last;
    } t_vertex;

    localparam int  SETTLE     = 12;
    localparam int  STALL_MAX  = 5000;
    localparam int  TEX_LIMIT  = 4096;
    localparam longint VMAX    = 524287;
    localparam longint VMIN    = -524288;

    // arctangent of 2^-i in 2^32 units per turn
    localparam longint ATAN_TBL [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [sqrs_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [sqrs_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic signed [sqrs_pkg::POS_W-1:0] i_pos_x = '0, i_pos_y = '0;
    logic [sqrs_pkg::SRC_W-1:0] i_src_x = '0, i_src_y = '0, i_src_w = '0, i_src_h = '0;
    logic [sqrs_pkg::SCL_W-1:0] i_scale_x = '0, i_scale_y = '0;
    logic [sqrs_pkg::ANG_W-1:0] i_angle = '0;
    logic                  o_strobe;
    logic signed [sqrs_pkg::VERT_W-1:0] o_vert_x, o_vert_y;
    logic [sqrs_pkg::TEX_W-1:0] o_tex_u, o_tex_v;
    logic [1:0]            o_corner;
    logic                  o_last;

    sprite_quad_rotate_scale_setup uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_src_x(i_src_x), .i_src_y(i_src_y), .i_src_w(i_src_w), .i_src_h(i_src_h),
        .i_scale_x(i_scale_x), .i_scale_y(i_scale_y), .i_angle(i_angle),
        .o_strobe(o_strobe), .o_vert_x(o_vert_x), .o_vert_y(o_vert_y),
        .o_tex_u(o_tex_u), .o_tex_v(o_tex_v), .o_corner(o_corner), .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    t_sprite_req pending [$];
    t_vertex     vertex_exp [$];
    t_sprite_req cur;
    logic [sqrs_pkg::CFG_W-1:0] tex_w_reg = sqrs_pkg::CFG_RESET;
    logic [sqrs_pkg::CFG_W-1:0] tex_h_reg = sqrs_pkg::CFG_RESET;
    int errors = 0;
    int draws_planned = 0;
    int draws_taken = 0;
    int quiet = 0;
    int stall_cnt = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // fixed-point cordic, cosine and sine in q1.30
    task automatic cordic_sincos(input logic [sqrs_pkg::ANG_W-1:0] ang,
                                 output longint c, output longint s);
        logic [31:0] ph;
        logic        flip;
        longint      x, y, z, xs, ys;
        ph = {ang, 16'd0};
        flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
        if (flip) ph = ph - 32'h80000000;
        x = 652032874;
        y = 0;
        z = longint'($signed(ph));
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_TBL[i];
            end else begin
                x += ys; y -= xs; z += ATAN_TBL[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic signed [sqrs_pkg::VERT_W-1:0] vert_round(input longint rot,
                                                                      input longint pos);
        longint v;
        v = (rot + (pos <<< 35) + (64'sd1 <<< 34)) >>> 35;
        if (v > VMAX) v = VMAX;
        if (v < VMIN) v = VMIN;
        return v[sqrs_pkg::VERT_W-1:0];
    endfunction

    function automatic logic [sqrs_pkg::TEX_W-1:0] tex_norm(input longint edge_t,
                                                           input longint size);
        longint q;
        q = (edge_t * 65536 + size / 2) / size;
        if (q > 262143) q = 262143;
        return q[sqrs_pkg::TEX_W-1:0];
    endfunction

    function automatic longint size_clamp(input logic [sqrs_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > TEX_LIMIT) return TEX_LIMIT;
        return longint'(v);
    endfunction

    task automatic predict_quad(input t_sprite_req d);
        longint c, s, hw, hh, dx, dy, tw, th, px, py;
        t_vertex vx;
        px = d.pos_x;
        py = d.pos_y;
        hw = longint'(d.src_w) * longint'(d.scale_x);
        hh = longint'(d.src_h) * longint'(d.scale_y);
        tw = size_clamp(tex_w_reg);
        th = size_clamp(tex_h_reg);
        cordic_sincos(d.angle, c, s);
        for (int k = 0; k < 4; k++) begin
            dx = k[0] ? hw : -hw;
            dy = k[1] ? hh : -hh;
            vx.vert_x = vert_round(dx * c - dy * s, px);
            vx.vert_y = vert_round(dx * s + dy * c, py);
            vx.tex_u  = k[0] ? tex_norm(longint'(d.src_x) + longint'(d.src_w), tw)
                             : tex_norm(longint'(d.src_x), tw);
            vx.tex_v  = k[1] ? tex_norm(longint'(d.src_y) + longint'(d.src_h), th)
                             : tex_norm(longint'(d.src_y), th);
            vx.corner = k[1:0];
            vx.last   = (k == 3);
            vertex_exp.push_back(vx);
        end
    endtask

    task automatic add_draw(input int px, input int py, input int sx, input int sy,
                            input int sw, input int sh, input int kx, input int ky,
                            input int ang);
        t_sprite_req r;
        r.op = OP_DRAW;
        r.pos_x = px; r.pos_y = py;
        r.src_x = sx; r.src_y = sy; r.src_w = sw; r.src_h = sh;
        r.scale_x = kx; r.scale_y = ky; r.angle = ang;
        r.cfg_idx = '0; r.cfg_data = '0;
        pending.push_back(r);
        draws_planned++;
    endtask

    task automatic add_ctrl(input t_op op, input int idx, input int data);
        t_sprite_req r;
        r.op = op;
        r.pos_x = '0; r.pos_y = '0;
        r.src_x = '0; r.src_y = '0; r.src_w = '0; r.src_h = '0;
        r.scale_x = '0; r.scale_y = '0; r.angle = '0;
        r.cfg_idx = idx;
        r.cfg_data = data;
        pending.push_back(r);
    endtask

    function automatic int rand_src();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 4096;
            2, 3: return $urandom_range(0, 4095);
            default: return $urandom_range(0, 64);
        endcase
    endfunction

    function automatic int rand_scale();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 65535);
            1: return 16'hFFFF;
            default: return $urandom_range(64, 1024);
        endcase
    endfunction

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) begin
            add_draw($urandom_range(0, 65535), $urandom_range(0, 65535),
                     rand_src(), rand_src(), rand_src(), rand_src(),
                     rand_scale(), rand_scale(), $urandom_range(0, 65535));
        end
    endtask

    // driver: one transaction in flight on the command port
    always @(posedge i_clk) begin : drive
        logic take, start_n, cfg_we_n;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            cfg_we_n = 1'b0;
            take = start && !busy;
            if (take) begin
                predict_quad(cur);
                draws_taken++;
            end
            if (o_strobe || start) quiet = 0;
            else quiet++;
            if (take || !start) begin
                start_n = 1'b0;
                if (pending.size() > 0) begin
                    if (pending[0].op != OP_DRAW) begin
                        if (!start && vertex_exp.size() == 0 && quiet >= SETTLE) begin
                            cur = pending.pop_front();
                            if (cur.op == OP_CFG) begin
                                cfg_we_n   = 1'b1;
                                i_cfg_idx  <= cur.cfg_idx;
                                i_cfg_data <= cur.cfg_data;
                                if (cur.cfg_idx == sqrs_pkg::CFG_TEX_WIDTH)
                                    tex_w_reg = cur.cfg_data;
                                else if (cur.cfg_idx == sqrs_pkg::CFG_TEX_HEIGHT)
                                    tex_h_reg = cur.cfg_data;
                            end
                            quiet = 0;
                        end
                    end else if ($urandom_range(1, 100) >
                                 (draws_taken < draws_planned / 3 ? 33 :
                                  draws_taken < 2 * draws_planned / 3 ? 56 : 0)) begin
                        cur = pending.pop_front();
                        start_n = 1'b1;
                        i_pos_x <= cur.pos_x;     i_pos_y <= cur.pos_y;
                        i_src_x <= cur.src_x;     i_src_y <= cur.src_y;
                        i_src_w <= cur.src_w;     i_src_h <= cur.src_h;
                        i_scale_x <= cur.scale_x; i_scale_y <= cur.scale_y;
                        i_angle <= cur.angle;
                    end
                end
                start <= start_n;
            end
            i_cfg_we <= cfg_we_n;
        end
    end

    // monitor: every strobed vertex is checked against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_vertex e;
        if (i_rst_n && o_strobe) begin
            if (vertex_exp.size() == 0) begin
                report_mismatch("unexpected vertex, corner", o_corner, -1);
            end else begin
                e = vertex_exp.pop_front();
                if (o_vert_x !== e.vert_x) report_mismatch("vert_x", o_vert_x, e.vert_x);
                if (o_vert_y !== e.vert_y) report_mismatch("vert_y", o_vert_y, e.vert_y);
                if (o_tex_u !== e.tex_u) report_mismatch("tex_u", o_tex_u, e.tex_u);
                if (o_tex_v !== e.tex_v) report_mismatch("tex_v", o_tex_v, e.tex_v);
                if (o_corner !== e.corner) report_mismatch("corner", o_corner, e.corner);
                if (o_last !== e.last) report_mismatch("last", o_last, e.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe || i_cfg_we) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= STALL_MAX) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin
        // directed: extremes, quadrant boundaries, saturation
        add_draw(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_draw(16, -16, 0, 0, 16, 16, 256, 256, 0);
        add_draw(0, 0, 0, 0, 16, 16, 256, 256, 16'h4000);
        add_draw(0, 0, 0, 0, 16, 16, 256, 256, 16'h8000);
        add_draw(0, 0, 0, 0, 16, 16, 256, 256, 16'hC000);
        add_draw(0, 0, 0, 0, 16, 16, 256, 256, 16'hFFFF);
        add_draw(0, 0, 0, 0, 16, 16, 256, 256, 16'h2000);
        add_draw(32767, 32767, 4096, 4096, 4096, 4096, 65535, 65535, 0);
        add_draw(-32768, -32768, 4096, 4096, 4096, 4096, 65535, 65535, 16'h6000);
        add_draw(32767, -32768, 4095, 0, 4095, 1, 65535, 1, 16'h3FFF);
        add_draw(-32768, 32767, 1, 4095, 1, 4095, 1, 65535, 16'hBFFF);
        add_draw(-1, -1, 2048, 2048, 2048, 2048, 128, 128, 16'h8001);
        add_ctrl(OP_DRAIN, 0, 0);
        add_random(110);
        // zero size clamps to one, oversize clamps to the maximum
        add_ctrl(OP_CFG, sqrs_pkg::CFG_TEX_WIDTH, 0);
        add_ctrl(OP_CFG, sqrs_pkg::CFG_TEX_HEIGHT, 8191);
        add_ctrl(OP_CFG, 2, 5);
        add_ctrl(OP_CFG, 3, 7);
        add_draw(0, 0, 4096, 4096, 4096, 4096, 256, 256, 0);
        add_draw(0, 0, 0, 1, 1, 2, 256, 256, 0);
        add_random(110);
        add_ctrl(OP_CFG, sqrs_pkg::CFG_TEX_WIDTH, 1);
        add_ctrl(OP_CFG, sqrs_pkg::CFG_TEX_HEIGHT, 1);
        add_draw(0, 0, 3, 2, 1, 1, 256, 256, 0);
        add_random(110);
        add_ctrl(OP_CFG, sqrs_pkg::CFG_TEX_WIDTH, 300);
        add_ctrl(OP_CFG, sqrs_pkg::CFG_TEX_HEIGHT, 4097);
        add_random(60);
        add_ctrl(OP_CFG, sqrs_pkg::CFG_TEX_WIDTH, 4096);
        add_ctrl(OP_CFG, sqrs_pkg::CFG_TEX_HEIGHT, 13);
        add_random(60);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending.size() == 0 && !start && vertex_exp.size() == 0);
        repeat (20) @(posedge i_clk);
        if (vertex_exp.size() != 0) report_mismatch("vertices left over", vertex_exp.size(), 0);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
